// File: rtl/cigar_string_parser_defines.svh
// ----------------------------------------------------------------------------
// cigar_string_parser_defines
// Assertion macros used by the CIGAR string parser top level.
// ----------------------------------------------------------------------------
`ifndef CIGAR_STRING_PARSER_DEFINES_SVH
`define CIGAR_STRING_PARSER_DEFINES_SVH

// check a condition at every clock edge out of reset
`define CSP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// check that a condition implies another in the same cycle
`define CSP_ASSERT_IMPLY(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

// File: rtl/csp_pkg.sv
// ----------------------------------------------------------------------------
// csp_pkg
// Types, widths and character codes of the CIGAR string parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package csp_pkg;

    localparam int READ_COORD_BITS = 20;
    localparam int REF_COORD_BITS  = 31;
    localparam int SCORE_BITS      = 24;
    localparam int CUR_BITS        = READ_COORD_BITS + 1;

    localparam int W_CH    = 8;
    localparam int W_START = 31;
    localparam int W_RLEN  = 20;
    localparam int W_READ  = 20;
    localparam int W_REF   = 31;
    localparam int W_OP    = 4;
    localparam int W_SCORE = 23;

    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = 2;
    localparam int Q_CNT_BITS = 3;

    localparam logic [7:0] CH_ZERO = "0";
    localparam logic [7:0] CH_NINE = "9";
    localparam logic [7:0] CH_M    = "M";
    localparam logic [7:0] CH_I    = "I";
    localparam logic [7:0] CH_D    = "D";
    localparam logic [7:0] CH_N    = "N";
    localparam logic [7:0] CH_LN   = "n";
    localparam logic [7:0] CH_S    = "S";
    localparam logic [7:0] CH_H    = "H";
    localparam logic [7:0] CH_EQ   = "=";
    localparam logic [7:0] CH_X    = "X";
    localparam logic [7:0] CH_P    = "P";

    localparam logic [W_OP-1:0] OP_M  = 4'd0;
    localparam logic [W_OP-1:0] OP_I  = 4'd1;
    localparam logic [W_OP-1:0] OP_D  = 4'd2;
    localparam logic [W_OP-1:0] OP_N  = 4'd3;
    localparam logic [W_OP-1:0] OP_S  = 4'd4;
    localparam logic [W_OP-1:0] OP_H  = 4'd5;
    localparam logic [W_OP-1:0] OP_EQ = 4'd6;
    localparam logic [W_OP-1:0] OP_X  = 4'd7;
    localparam logic [W_OP-1:0] OP_LN = 4'd8;

    typedef enum logic [1:0] {
        KIND_SEG = 2'd0,
        KIND_SUM = 2'd1,
        KIND_ERR = 2'd2
    } t_kind;

    typedef struct packed {
        logic [W_CH-1:0]    ch;
        logic               first;
        logic               last;
        logic [W_START-1:0] start_pos;
        logic [W_RLEN-1:0]  read_length;
    } t_in;

    typedef struct packed {
        t_kind                      kind;
        logic [W_READ-1:0]          read_start;
        logic [W_READ-1:0]          read_end;
        logic [W_REF-1:0]           ref_start;
        logic [W_REF-1:0]           ref_end;
        logic [W_OP-1:0]            op_code;
        logic [W_READ-1:0]          op_length;
        logic [W_READ-1:0]          aligned_len;
        logic [W_READ-1:0]          clip_total;
        logic signed [W_SCORE-1:0]  score;
        logic                       length_ok;
        logic                       last_out;
    } t_res;

    typedef struct packed {
        logic [READ_COORD_BITS-1:0] run_accum;
        logic [REF_COORD_BITS-1:0]  ref_cursor;
        logic [CUR_BITS-1:0]        read_cursor;
        logic [CUR_BITS-1:0]        prev_read_end;
        logic [REF_COORD_BITS-1:0]  prev_ref_end;
        logic [READ_COORD_BITS-1:0] aligned_total;
        logic [READ_COORD_BITS-1:0] head_clip;
        logic [READ_COORD_BITS-1:0] tail_clip;
        logic [READ_COORD_BITS-1:0] hard_clip_total;
        logic signed [SCORE_BITS-1:0] running_score;
        logic [READ_COORD_BITS-1:0] expected_length;
        logic                       error_hold;
    } t_state;

    typedef struct packed {
        logic [1:0] cnt;
        t_res       res0;
        t_res       res1;
    } t_push;

    typedef struct packed {
        logic [Q_CNT_BITS-1:0] count;
        logic                  room;
    } t_qstat;

endpackage

// File: rtl/cigar_string_parser.sv
// Path: a character is held in the input stage, its words then in the result queue.
// Throughput: one character per cycle while the queue has room; a closing operation
// marked last yields two words, so the output port at one word per cycle sets the rate.
// Reset: synchronous, active low; clears parse state, input stage valid and queue.
// ----------------------------------------------------------------------------
// cigar_string_parser
// Streaming CIGAR parser: segments per operation, summary on the last word, error words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cigar_string_parser_defines.svh"

module cigar_string_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // ch[7:0], start_pos[38:8], read_length[58:39], zero[63:59]
    input  logic [63:0]  i_s_axis_tdata,
    input  logic         i_s_axis_tlast,
    // first[0]
    input  logic [0:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // read_start[19:0], read_end[39:20], ref_start[70:40], ref_end[101:71],
    // op_code[105:102], op_length[125:106], aligned_len[145:126],
    // clip_total[165:146], score[188:166], length_ok[189], zero[215:190]
    output logic [215:0] o_m_axis_tdata,
    output logic         o_m_axis_tlast,
    // kind[1:0]
    output logic [1:0]   o_m_axis_tuser
);
    import csp_pkg::*;

    logic   r_iv;
    t_in    r_in;
    logic   fire;
    logic   accept;
    t_push  push;
    t_qstat q_stat;
    t_res   head;
    logic   push_err;
    logic   err_alone;

    assign fire            = r_iv && q_stat.room;
    assign o_s_axis_tready = !r_iv || fire;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in.ch          <= i_s_axis_tdata[7:0];
            r_in.start_pos   <= i_s_axis_tdata[38:8];
            r_in.read_length <= i_s_axis_tdata[58:39];
            r_in.first       <= i_s_axis_tuser[0];
            r_in.last        <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (accept) begin
            r_iv <= 1'b1;
        end else if (fire) begin
            r_iv <= 1'b0;
        end
    end

    csp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fire),
        .i_item  (r_in),
        .o_push  (push)
    );

    csp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    assign o_m_axis_tdata = {26'd0, head.length_ok, head.score, head.clip_total,
                             head.aligned_len, head.op_length, head.op_code,
                             head.ref_end, head.ref_start, head.read_end,
                             head.read_start};
    assign o_m_axis_tlast = head.last_out;
    assign o_m_axis_tuser = head.kind;

    assign push_err  = (push.cnt != 2'd0) && (push.res0.kind == KIND_ERR);
    assign err_alone = (push.cnt == 2'd1) && push.res0.last_out;

    `CSP_ASSERT_ALWAYS(a_q_bound, q_stat.count <= Q_CNT_BITS'(Q_DEPTH), "result queue overfilled")
    `CSP_ASSERT_IMPLY(a_push_on_fire, push.cnt != 2'd0, fire, "result pushed without a word")
    `CSP_ASSERT_IMPLY(a_err_single, push_err, err_alone, "error word not alone")

endmodule

// File: rtl/csp_core.sv
// ----------------------------------------------------------------------------
// csp_core
// Per-character parse step: run length, cursors, totals, segment and summary.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csp_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  csp_pkg::t_in    i_item,
    output csp_pkg::t_push  o_push
);
    import csp_pkg::*;

    localparam int RB  = READ_COORD_BITS;
    localparam int FB  = REF_COORD_BITS;
    localparam int SB  = SCORE_BITS;
    localparam int SCW = ((SB > RB + 1) ? SB : RB + 1) + 1;
    localparam int FIELD_MAX = (1 << W_READ) - 1;
    localparam int SCORE_HI  = (1 << (W_SCORE - 1)) - 1;
    localparam int SCORE_LO  = -(1 << (W_SCORE - 1));

    t_state r_st;
    t_state n_st;
    t_state base;
    t_state op_st;
    t_res   seg;
    t_res   err_res;
    logic   is_digit;
    logic   is_op;
    logic [RB+3:0] run_mul;
    logic [RB-1:0] run_next;
    logic [RB-1:0]  dx;
    logic [CUR_BITS-1:0] x1;
    logic [CUR_BITS-1:0] x1o;
    logic [CUR_BITS-1:0] x2;
    logic [FB-1:0] a1;
    logic [FB-1:0] a2;
    logic [3:0]    pen;
    logic signed [SCW-1:0] rs_ext;
    logic [W_OP-1:0] code;

    function automatic t_state reset_state();
        t_state s;
        s = '0;
        s.read_cursor = CUR_BITS'(1);
        return s;
    endfunction

    function automatic logic [RB-1:0] sat_add(logic [RB-1:0] a, logic [RB-1:0] b);
        logic [RB:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[RB] ? '1 : s[RB-1:0];
    endfunction

    function automatic logic signed [SB-1:0] sat_score(logic signed [SCW-1:0] v);
        logic signed [SB-1:0] r;
        if (v[SCW-1:SB-1] == '0 || v[SCW-1:SB-1] == '1) begin
            r = v[SB-1:0];
        end else if (v[SCW-1]) begin
            r = {1'b1, {(SB-1){1'b0}}};
        end else begin
            r = {1'b0, {(SB-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic t_res summary(t_state s);
        logic signed [RB+2:0]   clip;
        logic signed [CUR_BITS:0] diff;
        logic                   ok;
        logic signed [SB-1:0]   sc;
        logic [CUR_BITS-1:0]    rs_sum;
        t_res                   r;
        r      = '0;
        clip   = $signed({3'b000, s.head_clip}) + $signed({3'b000, s.tail_clip})
                 - $signed({3'b000, s.hard_clip_total});
        diff   = $signed({1'b0, s.prev_read_end})
                 - $signed({{(CUR_BITS+1-RB){1'b0}}, s.hard_clip_total});
        ok     = (diff == $signed({{(CUR_BITS+1-RB){1'b0}}, s.expected_length}));
        sc     = ok ? s.running_score : '1;
        if (clip < 0) begin
            clip = '0;
        end else if (clip > FIELD_MAX) begin
            clip = (RB+3)'(FIELD_MAX);
        end
        if (sc > SCORE_HI) begin
            sc = SB'(SCORE_HI);
        end else if (sc < SCORE_LO) begin
            sc = SB'(SCORE_LO);
        end
        rs_sum       = CUR_BITS'(s.head_clip) + CUR_BITS'(1);
        r.kind       = KIND_SUM;
        r.read_start = W_READ'(rs_sum);
        r.read_end   = W_READ'(s.prev_read_end - CUR_BITS'(s.tail_clip));
        r.ref_end    = W_REF'(s.prev_ref_end);
        r.aligned_len = W_READ'(s.aligned_total);
        r.clip_total = W_READ'(clip);
        r.score      = W_SCORE'(sc);
        r.length_ok  = ok;
        r.last_out   = 1'b1;
        return r;
    endfunction

    always_comb begin
        base = r_st;
        if (i_item.first) begin
            base                 = reset_state();
            base.ref_cursor      = FB'(i_item.start_pos);
            base.prev_ref_end    = FB'(i_item.start_pos);
            base.expected_length = RB'(i_item.read_length);
        end
    end

    assign is_digit = (i_item.ch >= CH_ZERO) && (i_item.ch <= CH_NINE);
    assign run_mul  = (RB+4)'(base.run_accum) * (RB+4)'(10)
                      + (RB+4)'(i_item.ch - CH_ZERO);
    assign run_next = (run_mul > (RB+4)'({RB{1'b1}})) ? '1 : run_mul[RB-1:0];

    assign dx     = base.run_accum;
    assign x1     = base.read_cursor;
    assign a1     = base.ref_cursor;
    assign pen    = (dx > RB'(3)) ? 4'd12 : {dx[1:0], 2'b00};
    assign rs_ext = SCW'(base.running_score);

    always_comb begin
        op_st = base;
        is_op = 1'b1;
        code  = OP_M;
        x1o   = x1;
        x2    = x1 + CUR_BITS'(dx) - CUR_BITS'(1);
        a2    = a1 + FB'(dx) - FB'(1);
        unique case (i_item.ch)
            CH_M, CH_X, CH_EQ: begin
                code = (i_item.ch == CH_M) ? OP_M : ((i_item.ch == CH_X) ? OP_X : OP_EQ);
                if (i_item.ch == CH_EQ) begin
                    op_st.running_score = sat_score(rs_ext + $signed({{(SCW-RB){1'b0}}, dx}));
                end
                op_st.aligned_total = sat_add(base.aligned_total, dx);
            end
            CH_I: begin
                code = OP_I;
                a2   = a1 - FB'(1);
                op_st.running_score = sat_score(rs_ext - $signed({{(SCW-4){1'b0}}, pen}));
            end
            CH_D: begin
                code = OP_D;
                x2   = x1 - CUR_BITS'(1);
                op_st.running_score = sat_score(rs_ext - $signed({{(SCW-4){1'b0}}, pen}));
            end
            CH_N, CH_LN: begin
                code = (i_item.ch == CH_N) ? OP_N : OP_LN;
                x2   = x1 - CUR_BITS'(1);
            end
            CH_S, CH_H: begin
                code = (i_item.ch == CH_S) ? OP_S : OP_H;
                if (i_item.ch == CH_H) begin
                    op_st.hard_clip_total = sat_add(base.hard_clip_total, dx);
                end
                a2  = a1 - FB'(1);
                x1o = x1 + CUR_BITS'(dx);
                x2  = x1o - CUR_BITS'(1);
                if (base.aligned_total == '0) begin
                    op_st.head_clip = sat_add(base.head_clip, dx);
                end else begin
                    op_st.tail_clip = sat_add(base.tail_clip, dx);
                end
            end
            default: begin
                is_op = 1'b0;
            end
        endcase
        op_st.prev_read_end = x2;
        op_st.prev_ref_end  = a2;
        op_st.read_cursor   = x2 + CUR_BITS'(1);
        op_st.ref_cursor    = a2 + FB'(1);
        op_st.run_accum     = '0;

        seg            = '0;
        seg.kind       = KIND_SEG;
        seg.read_start = W_READ'(x1o);
        seg.read_end   = W_READ'(x2);
        seg.ref_start  = W_REF'(a1);
        seg.ref_end    = W_REF'(a2);
        seg.op_code    = code;
        seg.op_length  = W_READ'(dx);
        seg.last_out   = !i_item.last;

        err_res          = '0;
        err_res.kind     = KIND_ERR;
        err_res.last_out = 1'b1;
    end

    always_comb begin
        n_st   = r_st;
        o_push = '0;
        if (i_valid && (i_item.first || !r_st.error_hold)) begin
            n_st = base;
            priority if (is_digit) begin
                if (i_item.last) begin
                    n_st.error_hold = 1'b1;
                    o_push.cnt      = 2'd1;
                    o_push.res0     = err_res;
                end else begin
                    n_st.run_accum = run_next;
                end
            end else if (i_item.ch == CH_P) begin
                n_st.run_accum = '0;
                if (i_item.last) begin
                    o_push.cnt  = 2'd1;
                    o_push.res0 = summary(n_st);
                end
            end else if (is_op) begin
                n_st        = op_st;
                o_push.res0 = seg;
                o_push.res1 = summary(op_st);
                o_push.cnt  = i_item.last ? 2'd2 : 2'd1;
            end else begin
                n_st.error_hold = 1'b1;
                o_push.cnt      = 2'd1;
                o_push.res0     = err_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= reset_state();
        end else begin
            r_st <= n_st;
        end
    end

endmodule

// File: rtl/csp_outq.sv
// ----------------------------------------------------------------------------
// csp_outq
// Small result queue: takes up to two words a cycle, hands out one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csp_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  csp_pkg::t_push  i_push,
    input  logic            i_pop,
    output logic            o_valid,
    output csp_pkg::t_res   o_head,
    output csp_pkg::t_qstat o_stat
);
    import csp_pkg::*;

    t_res                  r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr;
    logic [Q_PTR_BITS-1:0] r_rd;
    logic [Q_CNT_BITS-1:0] r_cnt;
    logic [Q_PTR_BITS-1:0] n_wr;
    logic [Q_PTR_BITS-1:0] n_rd;
    logic [Q_CNT_BITS-1:0] n_cnt;
    logic                  pop_ok;

    assign o_valid      = (r_cnt != '0);
    assign o_head       = r_mem[r_rd];
    assign pop_ok       = i_pop && o_valid;
    assign o_stat.count = r_cnt;
    assign o_stat.room  = (r_cnt <= Q_CNT_BITS'(Q_DEPTH - 2));

    always_comb begin
        n_wr  = r_wr + Q_PTR_BITS'(i_push.cnt);
        n_rd  = r_rd + Q_PTR_BITS'(pop_ok);
        n_cnt = r_cnt + Q_CNT_BITS'(i_push.cnt) - Q_CNT_BITS'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wr + Q_PTR_BITS'(1)] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule
